### rtl/core/fledb_pkg.sv
// Shared types and constants for the fault LED and beeper annunciator.
package fledb_pkg;

    localparam int MOTOR_COUNT = 4;
    localparam int MOTOR_BITS  = 4;

    localparam logic [MOTOR_BITS-1:0] MOTOR_MASK =
        (MOTOR_COUNT >= MOTOR_BITS) ? {MOTOR_BITS{1'b1}}
                                    : MOTOR_BITS'((1 << MOTOR_COUNT) - 1);

    localparam logic [13:0] TICK_WRAP  = 14'd10000;
    localparam logic [6:0]  PHASE_LAST = 7'd99;
    localparam logic [4:0]  M20_LAST   = 5'd19;

    localparam logic [10:0] HZ_1000 = 11'd1000;
    localparam logic [10:0] HZ_1200 = 11'd1200;
    localparam logic [10:0] HZ_1300 = 11'd1300;
    localparam logic [10:0] HZ_1500 = 11'd1500;

    localparam logic [1:0] LINK_FAIL    = 2'd1;
    localparam logic [1:0] LINK_OFFLINE = 2'd2;

    localparam logic [1:0] CODE_NONE   = 2'd0;
    localparam logic [1:0] CODE_SINGLE = 2'd1;
    localparam logic [1:0] CODE_DOUBLE = 2'd2;

    localparam int IN_BITS  = 10;
    localparam int OUT_BITS = 19;

    typedef struct packed {
        logic                  key_pressed;
        logic [MOTOR_BITS-1:0] motor_errors;
        logic                  remote_error;
        logic                  supercap_closed;
        logic                  aux_link_error;
        logic [1:0]            link_state;
    } in_item_t;

    typedef struct packed {
        logic [10:0]           beep_freq_hz;
        logic                  beep_on;
        logic                  aux_led_lit;
        logic [MOTOR_BITS-1:0] motor_leds_lit;
        logic                  red_pin_high;
        logic                  green_pin_high;
    } out_item_t;

    typedef struct packed {
        logic [13:0] count;
        logic [6:0]  phase;
        logic [4:0]  m20;
    } tick_t;

endpackage

### rtl/core/fledb_tick_ctr.sv
// Tick counter with its mod-100 phase and mod-20 companion counters.
module fledb_tick_ctr (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            advance,
    output fledb_pkg::tick_t tick_next
);

    logic [13:0] count_reg;
    logic [6:0]  phase_reg;
    logic [4:0]  m20_reg;

    always_comb begin
        if (count_reg < fledb_pkg::TICK_WRAP) begin
            tick_next.count = count_reg + 14'd1;
            tick_next.phase = (phase_reg == fledb_pkg::PHASE_LAST) ? 7'd0 : phase_reg + 7'd1;
            tick_next.m20   = (m20_reg == fledb_pkg::M20_LAST) ? 5'd0 : m20_reg + 5'd1;
        end else begin
            tick_next.count = 14'd0;
            tick_next.phase = 7'd0;
            tick_next.m20   = 5'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 14'd0;
            phase_reg <= 7'd0;
            m20_reg   <= 5'd0;
        end else if (advance) begin
            count_reg <= tick_next.count;
            phase_reg <= tick_next.phase;
            m20_reg   <= tick_next.m20;
        end
    end

endmodule

### rtl/core/fledb_annunc.sv
// Annunciator state and the per-tick pin, LED and beeper decisions.
module fledb_annunc (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  fledb_pkg::tick_t     tick,
    input  fledb_pkg::in_item_t  item,
    output fledb_pkg::out_item_t result
);

    logic        prev_fatal_reg, mute_reg, green_reg, red_reg, aux_reg, beep_reg;
    logic [10:0] pitch_reg;

    logic        green_next, red_next, aux_next, beep_next, mute_next, fatal;
    logic [10:0] pitch_next;
    logic [1:0]  green_mode, red_mode;
    logic [6:0]  p;
    logic [fledb_pkg::MOTOR_BITS-1:0] leds;
    logic        dbl_win, dbl_gap;

    always_comb begin
        p          = tick.phase;
        green_next = green_reg;
        red_next   = red_reg;
        aux_next   = aux_reg;
        beep_next  = beep_reg;
        pitch_next = pitch_reg;
        dbl_win    = (p > 7'd50 && p < 7'd60) || (p > 7'd70 && p < 7'd80);
        dbl_gap    = (p > 7'd60 && p < 7'd70) || p > 7'd80;

        if (item.link_state == fledb_pkg::LINK_OFFLINE) begin
            green_mode = fledb_pkg::CODE_DOUBLE;
        end else if (item.link_state == fledb_pkg::LINK_FAIL) begin
            green_mode = fledb_pkg::CODE_SINGLE;
        end else begin
            green_mode = fledb_pkg::CODE_NONE;
        end
        if (item.remote_error) begin
            red_mode = fledb_pkg::CODE_SINGLE;
        end else if (item.supercap_closed) begin
            red_mode = fledb_pkg::CODE_DOUBLE;
        end else begin
            red_mode = fledb_pkg::CODE_NONE;
        end

        case (green_mode)
            fledb_pkg::CODE_NONE: begin
                green_next = 1'b0;
            end
            fledb_pkg::CODE_SINGLE: begin
                green_next = (p >= 7'd10);
            end
            default: begin
                if (p < 7'd10 || (p > 7'd20 && p < 7'd30)) begin
                    green_next = 1'b0;
                    beep_next  = 1'b1;
                    pitch_next = (p > 7'd20) ? fledb_pkg::HZ_1000 : fledb_pkg::HZ_1300;
                end else if (p < 7'd20 || p > 7'd30) begin
                    green_next = 1'b1;
                    beep_next  = 1'b0;
                end
            end
        endcase

        if (green_mode == fledb_pkg::CODE_NONE && red_mode == fledb_pkg::CODE_NONE
                && !prev_fatal_reg) begin
            beep_next = 1'b0;
        end

        case (red_mode)
            fledb_pkg::CODE_NONE: begin
                red_next = 1'b0;
            end
            fledb_pkg::CODE_SINGLE: begin
                if (p < 7'd10) begin
                    red_next   = 1'b0;
                    beep_next  = 1'b1;
                    pitch_next = fledb_pkg::HZ_1500;
                end else begin
                    red_next  = 1'b1;
                    beep_next = 1'b0;
                end
            end
            default: begin
                if (dbl_win) begin
                    red_next   = 1'b0;
                    beep_next  = 1'b1;
                    pitch_next = (p > 7'd70) ? fledb_pkg::HZ_1200 : fledb_pkg::HZ_1000;
                end else if (dbl_gap) begin
                    red_next  = 1'b1;
                    beep_next = 1'b0;
                end
            end
        endcase

        leds  = item.motor_errors & fledb_pkg::MOTOR_MASK;
        fatal = |leds;
        if (fatal) begin
            if (tick.m20 < 5'd5) begin
                red_next   = 1'b0;
                beep_next  = 1'b1;
                pitch_next = fledb_pkg::HZ_1000;
            end else begin
                red_next  = 1'b1;
                beep_next = 1'b0;
            end
        end

        if (item.aux_link_error) begin
            if (dbl_win) begin
                aux_next   = 1'b1;
                beep_next  = 1'b1;
                pitch_next = (p > 7'd70) ? fledb_pkg::HZ_1200 : fledb_pkg::HZ_1000;
            end else if (dbl_gap) begin
                aux_next  = 1'b0;
                beep_next = 1'b0;
            end
        end else begin
            aux_next = 1'b0;
        end

        mute_next = mute_reg | item.key_pressed;
        if (mute_next) begin
            beep_next = 1'b0;
        end

        result.green_pin_high = green_next;
        result.red_pin_high   = red_next;
        result.motor_leds_lit = leds;
        result.aux_led_lit    = aux_next;
        result.beep_on        = beep_next;
        result.beep_freq_hz   = pitch_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_fatal_reg <= 1'b0;
            mute_reg       <= 1'b0;
            green_reg      <= 1'b1;
            red_reg        <= 1'b1;
            aux_reg        <= 1'b0;
            beep_reg       <= 1'b0;
            pitch_reg      <= fledb_pkg::HZ_1000;
        end else if (advance) begin
            prev_fatal_reg <= fatal;
            mute_reg       <= mute_next;
            green_reg      <= green_next;
            red_reg        <= red_next;
            aux_reg        <= aux_next;
            beep_reg       <= beep_next;
            pitch_reg      <= pitch_next;
        end
    end

endmodule

### rtl/core/fault_led_beeper_annunciator.sv
// Top level: input register, tick decision logic and output register.
// A word accepted into the input register gives its result word on m_tdata through the output register.
// Throughput: one word per cycle while m_tready is high; at most two words are in flight.
// A stalled result holds the input register, and s_tready drops once both registers are full.
// Reset (aresetn low, synchronous) empties both registers, zeroes the tick counter,
// drives green and red high, clears mute, aux and beeper, and sets the pitch to 1000 Hz.
module fault_led_beeper_annunciator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // link_state[1:0], aux_link_error[2], supercap_closed[3], remote_error[4],
    // motor_errors[8:5], key_pressed[9], zero[15:10]
    input  logic [15:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // green_pin_high[0], red_pin_high[1], motor_leds_lit[5:2], aux_led_lit[6],
    // beep_on[7], beep_freq_hz[18:8], zero[23:19]
    output logic [23:0] m_tdata
);

    logic                 in_valid_reg, in_valid_next;
    fledb_pkg::in_item_t  in_item_reg;
    logic                 out_valid_reg, out_valid_next;
    fledb_pkg::out_item_t out_item_reg;
    fledb_pkg::out_item_t result;
    fledb_pkg::tick_t     tick_next;
    logic                 advance, s_take;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    assign in_valid_next  = s_take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    fledb_tick_ctr u_tick (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .tick_next (tick_next)
    );

    fledb_annunc u_annunc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .tick    (tick_next),
        .item    (in_item_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_item_reg <= fledb_pkg::in_item_t'(s_tdata[fledb_pkg::IN_BITS-1:0]);
        end
        if (advance) begin
            out_item_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(24 - fledb_pkg::OUT_BITS){1'b0}}, out_item_reg};

endmodule

### rtl/core/fledb_checker.sv
// Port-level checks for the annunciator, bound to the top level.
module fledb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("Result valid right after reset.");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Stalled result word changed.");

    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("Input stalled while the result side could move.");

    a_pitch_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[18:8] == fledb_pkg::HZ_1000 || m_tdata[18:8] == fledb_pkg::HZ_1200
                      || m_tdata[18:8] == fledb_pkg::HZ_1300
                      || m_tdata[18:8] == fledb_pkg::HZ_1500))
        else $error("Beeper pitch is not one of the four tones.");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[23:19] == 5'd0)
        else $error("Result padding bits are not zero.");

endmodule

bind fault_led_beeper_annunciator fledb_checker u_fledb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/fledb_panel_checker.sv
// Checker for the annunciator: predicts each panel word from the ticks and compares the results.
module fledb_panel_checker
    import fledb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    output int          mismatches,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_CAP = 200;

    logic [13:0] ticks;
    logic        last_fatal;
    logic        muted;
    logic        green;
    logic        red;
    logic        aux;
    logic        beeping;
    logic [10:0] pitch;

    out_item_t panel_due[$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    function automatic void set_beep(input bit on, input logic [10:0] hz);
        if (on) begin
            beeping = 1'b1;
            pitch   = hz;
        end else begin
            beeping = 1'b0;
        end
    endfunction

    function automatic bit paired_on(input int unsigned ph);
        return (ph > 50 && ph < 60) || (ph > 70 && ph < 80);
    endfunction

    function automatic bit paired_off(input int unsigned ph);
        return (ph > 60 && ph < 70) || ph > 80;
    endfunction

    function automatic out_item_t annunciate(input in_item_t w);
        int unsigned           ph;
        int unsigned           m20;
        logic [1:0]            gcode;
        logic [1:0]            rcode;
        logic [MOTOR_BITS-1:0] faulted;
        out_item_t             r;

        ticks = (ticks < TICK_WRAP) ? ticks + 14'd1 : 14'd0;
        ph    = ticks % 100;
        m20   = ticks % 20;

        if (w.link_state == LINK_OFFLINE)
            gcode = CODE_DOUBLE;
        else if (w.link_state == LINK_FAIL)
            gcode = CODE_SINGLE;
        else
            gcode = CODE_NONE;
        rcode = CODE_NONE;
        if (w.supercap_closed)
            rcode = CODE_DOUBLE;
        if (w.remote_error)
            rcode = CODE_SINGLE;

        case (gcode)
            CODE_NONE: green = 1'b0;
            CODE_SINGLE: green = (ph >= 10);
            default: begin
                if (ph < 10 || (ph > 20 && ph < 30)) begin
                    green = 1'b0;
                    set_beep(1'b1, (ph > 20) ? HZ_1000 : HZ_1300);
                end else if (ph < 20 || ph > 30) begin
                    green = 1'b1;
                    set_beep(1'b0, HZ_1500);
                end
            end
        endcase

        if (gcode == CODE_NONE && rcode == CODE_NONE && !last_fatal)
            set_beep(1'b0, HZ_1000);

        case (rcode)
            CODE_NONE: red = 1'b0;
            CODE_SINGLE: begin
                red = (ph >= 10);
                set_beep(ph < 10, HZ_1500);
            end
            default: begin
                if (paired_on(ph)) begin
                    red = 1'b0;
                    set_beep(1'b1, (ph > 70) ? HZ_1200 : HZ_1000);
                end else if (paired_off(ph)) begin
                    red = 1'b1;
                    set_beep(1'b0, HZ_1000);
                end
            end
        endcase

        faulted = w.motor_errors & MOTOR_MASK;
        if (faulted != '0) begin
            red = (m20 >= 5);
            set_beep(m20 < 5, HZ_1000);
        end
        last_fatal = (faulted != '0);

        if (w.aux_link_error) begin
            if (paired_on(ph)) begin
                aux = 1'b1;
                set_beep(1'b1, (ph > 70) ? HZ_1200 : HZ_1000);
            end else if (paired_off(ph)) begin
                aux = 1'b0;
                set_beep(1'b0, HZ_1000);
            end
        end else begin
            aux = 1'b0;
        end

        if (w.key_pressed)
            muted = 1'b1;
        if (muted)
            set_beep(1'b0, HZ_1000);

        r.green_pin_high = green;
        r.red_pin_high   = red;
        r.motor_leds_lit = faulted;
        r.aux_led_lit    = aux;
        r.beep_on        = beeping;
        r.beep_freq_hz   = pitch;
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        out_item_t got;
        out_item_t want;

        if (!aresetn) begin
            ticks      = '0;
            last_fatal = 1'b0;
            muted      = 1'b0;
            green      = 1'b1;
            red        = 1'b1;
            aux        = 1'b0;
            beeping    = 1'b0;
            pitch      = HZ_1000;
            panel_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = out_item_t'(m_tdata[OUT_BITS-1:0]);
                if (panel_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_CAP)
                        $display("%0t: result word %h arrived with none expected, got %h",
                                 $time, m_tdata, got);
                end else begin
                    want = panel_due.pop_front();
                    check_field("green_pin_high", want.green_pin_high, got.green_pin_high);
                    check_field("red_pin_high", want.red_pin_high, got.red_pin_high);
                    check_field("motor_leds_lit", want.motor_leds_lit, got.motor_leds_lit);
                    check_field("aux_led_lit", want.aux_led_lit, got.aux_led_lit);
                    check_field("beep_on", want.beep_on, got.beep_on);
                    check_field("beep_freq_hz", want.beep_freq_hz, got.beep_freq_hz);
                end
            end
            if (s_tvalid && s_tready)
                panel_due.push_back(annunciate(in_item_t'(s_tdata[IN_BITS-1:0])));
        end
        outstanding <= panel_due.size();
    end

endmodule

### tb/tb_fault_led_beeper_annunciator.sv
// Testbench top for the annunciator: clock, reset, tick stimulus, result stalls and verdict.
module tb_fault_led_beeper_annunciator;
    timeunit 1ns;
    timeprecision 1ps;

    import fledb_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_TICKS = 1600;
    localparam int CALM_FROM    = 700;
    localparam int CALM_TO      = 1000;

    localparam logic [1:0] LINK_NORMAL = 2'd0;
    localparam logic [1:0] LINK_UNUSED = 2'd3;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    int          mismatches;
    int          outstanding;
    int          sent;
    bit          calm;

    fault_led_beeper_annunciator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    fledb_panel_checker panel_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            m_tready <= calm || ($urandom_range(99) >= 36);
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("Regression FAIL");
        $finish;
    end

    function automatic in_item_t word_of(input logic [1:0] link, input logic aux,
                                         input logic cap, input logic rem,
                                         input logic [MOTOR_BITS-1:0] motors,
                                         input logic key);
        in_item_t w;
        w.link_state      = link;
        w.aux_link_error  = aux;
        w.supercap_closed = cap;
        w.remote_error    = rem;
        w.motor_errors    = motors;
        w.key_pressed     = key;
        return w;
    endfunction

    task automatic send_word(input in_item_t w);
        while (!calm && $urandom_range(99) < 36) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= 16'(w);
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // One fault situation held for a random number of ticks, with occasional noise words.
    task automatic play_scenario(input bit allow_key);
        in_item_t base;
        in_item_t w;
        int       len;

        base = in_item_t'(IN_BITS'($urandom));
        base.key_pressed = 1'b0;
        if ($urandom_range(3) != 0)
            base.motor_errors = '0;
        len = $urandom_range(120, 1);
        for (int i = 0; i < len; i++) begin
            w = base;
            if ($urandom_range(9) == 0)
                w = in_item_t'(IN_BITS'($urandom));
            if (!allow_key)
                w.key_pressed = 1'b0;
            send_word(w);
        end
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        calm     = 1'b0;
        sent     = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_word(word_of(LINK_NORMAL, 1'b0, 1'b0, 1'b0, 4'h0, 1'b0));
        send_word(word_of(LINK_FAIL, 1'b0, 1'b0, 1'b0, 4'h0, 1'b0));
        send_word(word_of(LINK_OFFLINE, 1'b0, 1'b0, 1'b0, 4'h0, 1'b0));
        send_word(word_of(LINK_UNUSED, 1'b0, 1'b0, 1'b0, 4'h0, 1'b0));
        send_word(word_of(LINK_NORMAL, 1'b1, 1'b0, 1'b0, 4'h0, 1'b0));
        send_word(word_of(LINK_NORMAL, 1'b0, 1'b1, 1'b0, 4'h0, 1'b0));
        send_word(word_of(LINK_NORMAL, 1'b0, 1'b0, 1'b1, 4'h0, 1'b0));
        send_word(word_of(LINK_NORMAL, 1'b0, 1'b1, 1'b1, 4'h0, 1'b0));
        send_word(word_of(LINK_NORMAL, 1'b0, 1'b0, 1'b0, 4'h1, 1'b0));
        send_word(word_of(LINK_NORMAL, 1'b0, 1'b0, 1'b0, 4'h0, 1'b0));
        send_word(word_of(LINK_NORMAL, 1'b0, 1'b0, 1'b0, 4'h2, 1'b0));
        send_word(word_of(LINK_NORMAL, 1'b0, 1'b0, 1'b0, 4'h4, 1'b0));
        send_word(word_of(LINK_NORMAL, 1'b0, 1'b0, 1'b0, 4'h8, 1'b0));
        send_word(word_of(LINK_NORMAL, 1'b0, 1'b0, 1'b0, 4'hF, 1'b0));
        send_word(word_of(LINK_NORMAL, 1'b0, 1'b0, 1'b0, 4'h0, 1'b0));
        send_word(word_of(LINK_OFFLINE, 1'b1, 1'b1, 1'b1, 4'hF, 1'b0));
        send_word(word_of(LINK_UNUSED, 1'b1, 1'b1, 1'b1, 4'hF, 1'b0));
        send_word(word_of(LINK_FAIL, 1'b1, 1'b1, 1'b0, 4'h0, 1'b0));
        send_word(word_of(LINK_NORMAL, 1'b0, 1'b0, 1'b0, 4'h0, 1'b0));
        drain();

        while (sent < RANDOM_TICKS) begin
            calm <= (sent >= CALM_FROM && sent < CALM_TO);
            play_scenario(1'b0);
            if ($urandom_range(39) == 0)
                drain();
        end
        calm <= 1'b0;

        // The mute latch never clears, so the key is only pressed at the very end.
        send_word(word_of(LINK_OFFLINE, 1'b1, 1'b1, 1'b0, 4'h3, 1'b1));
        repeat (3) play_scenario(1'b1);

        drain();
        repeat (10) @(posedge aclk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
